/* src/assert_macros.svh */
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define CSRE_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition that must never hold outside reset
`define CSRE_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

/* src/csre_pkg.sv */
// types and codes of the sdo request engine
package csre_pkg;

    localparam logic [1:0] OP_SUBMIT = 2'd0;
    localparam logic [1:0] OP_RX     = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;
    localparam logic [1:0] OP_REFUSE = 2'd3;

    localparam logic [1:0] PRIO_CRIT = 2'd0;
    localparam logic [1:0] PRIO_CTRL = 2'd1;

    localparam logic       KIND_FRAME = 1'b0;
    localparam logic       KIND_DONE  = 1'b1;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_SENDFAIL = 3'd1;
    localparam logic [2:0] ST_REJECTED = 3'd2;
    localparam logic [2:0] ST_TIMEOUT  = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;

    localparam logic [7:0] REJECT_CODE = 8'h80;
    localparam logic [3:0] MIN_RX_LEN  = 4'd4;
    localparam logic [3:0] MAX_LEN     = 4'd8;

    localparam logic [7:0] PERIOD_RESET = 8'd2;
    localparam logic [7:0] HOLD_RESET   = 8'd10;
    localparam logic [15:0] TAG_LAST    = 16'hFFFF;

    localparam logic REG_PERIOD = 1'b0;
    localparam logic REG_HOLD   = 1'b1;

    typedef struct packed {
        logic [1:0]  op;
        logic [10:0] frame_id;
        logic [3:0]  frame_len;
        logic [63:0] frame_bytes;
        logic [1:0]  priority_class;
        logic [15:0] request_tag;
        logic        wants_reply;
        logic [10:0] reply_id;
        logic [15:0] object_index;
        logic [7:0]  object_subindex;
        logic [15:0] wait_limit_ms;
    } t_in_item;

    typedef struct packed {
        logic        out_kind;
        logic [10:0] out_frame_id;
        logic [3:0]  out_len;
        logic [63:0] out_bytes;
        logic [15:0] done_tag;
        logic [2:0]  done_status;
        logic [15:0] latency_ms;
    } t_out_item;

    typedef struct packed {
        logic is_crit;
        logic is_ctrl;
    } t_cls;

    typedef struct packed {
        t_in_item item;
        t_cls     cls;
    } t_work;

    typedef struct packed {
        logic [15:0] tag;
        logic [10:0] fid;
        logic [3:0]  len;
        logic        crit;
        logic        wants;
        logic [15:0] wlim;
        logic [10:0] rid;
        logic [15:0] idx;
        logic [7:0]  sub;
        logic [63:0] bytes;
    } t_slot;

    typedef struct packed {
        logic busy;
        logic queue_full;
    } t_back_status;

endpackage

/* src/csre_front.sv */
// front: accepts beats, classifies them and buffers them for the back
module csre_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  csre_pkg::t_in_item i_in_item,
    output logic               o_work_valid,
    output csre_pkg::t_work    o_work,
    input  logic               i_work_take
);
    csre_pkg::t_work r_buf [2];
    logic            r_wptr, r_rptr;
    logic [1:0]      r_cnt;
    logic            push, pop;
    csre_pkg::t_cls  cls;

    always_comb begin
        cls.is_crit = (i_in_item.priority_class == csre_pkg::PRIO_CRIT);
        cls.is_ctrl = (i_in_item.priority_class == csre_pkg::PRIO_CTRL);
    end

    assign o_in_stall   = (r_cnt == 2'd2);
    assign push         = i_in_valid && !o_in_stall;
    assign o_work_valid = (r_cnt != 2'd0);
    assign pop          = o_work_valid && i_work_take;
    assign o_work       = r_buf[r_rptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf[r_wptr] <= '{item: i_in_item, cls: cls};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (push) r_wptr <= !r_wptr;
            if (pop)  r_rptr <= !r_rptr;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end
endmodule

/* src/csre_back.sv */
// back: request queue, transaction tracking and result register
module csre_back #(
    parameter int QUEUE_DEPTH = 16,
    parameter int CW = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_work_valid,
    input  csre_pkg::t_work         i_work,
    output logic                    o_work_take,
    input  logic [7:0]              i_cfg_period,
    input  logic [7:0]              i_cfg_hold,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output csre_pkg::t_out_item     o_out_item,
    output csre_pkg::t_back_status  o_status,
    output logic [CW-1:0]           o_count
);
    csre_pkg::t_slot     r_slot [QUEUE_DEPTH];
    csre_pkg::t_slot     n_slot [QUEUE_DEPTH];
    csre_pkg::t_slot     r_act, n_act, new_slot;
    logic [CW-1:0]       r_count, n_count, r_crit, n_crit, pos;
    logic [15:0]         r_next_tag, n_next_tag, r_elapsed, n_elapsed, tag_eff, limit;
    logic                r_busy, n_busy;
    logic [7:0]          r_phase, n_phase, phase_inc, period;
    logic                r_ov, go, res, ins, deq;
    csre_pkg::t_out_item r_out, res_item;
    csre_pkg::t_in_item  it;

    assign it          = i_work.item;
    assign go          = i_work_valid && (!r_ov || !i_out_stall);
    assign o_work_take = go;
    assign o_out_valid = r_ov;
    assign o_out_item  = r_out;
    assign o_count     = r_count;
    assign o_status    = '{busy: r_busy, queue_full: (r_count == CW'(QUEUE_DEPTH))};

    assign tag_eff   = (it.request_tag != 16'd0) ? it.request_tag : r_next_tag;
    assign phase_inc = r_phase + 8'd1;
    assign period    = (i_cfg_period != 8'd0) ? i_cfg_period : 8'd1;
    assign limit     = r_act.wants ? r_act.wlim : {8'd0, i_cfg_hold};

    always_comb begin
        new_slot = '{tag: tag_eff, fid: it.frame_id, len: it.frame_len,
                     crit: i_work.cls.is_crit, wants: it.wants_reply,
                     wlim: it.wait_limit_ms, rid: it.reply_id, idx: it.object_index,
                     sub: it.object_subindex, bytes: it.frame_bytes};
        if (i_work.cls.is_crit)      pos = '0;
        else if (i_work.cls.is_ctrl) pos = r_crit;
        else                         pos = r_count;
    end

    // decode one work beat
    always_comb begin
        n_count    = r_count;
        n_crit     = r_crit;
        n_next_tag = r_next_tag;
        n_busy     = r_busy;
        n_act      = r_act;
        n_elapsed  = r_elapsed;
        n_phase    = r_phase;
        res        = 1'b0;
        ins        = 1'b0;
        deq        = 1'b0;
        res_item   = '0;
        unique case (it.op)
            csre_pkg::OP_SUBMIT: begin
                if (r_count == CW'(QUEUE_DEPTH)) begin
                    res                  = 1'b1;
                    res_item.out_kind    = csre_pkg::KIND_DONE;
                    res_item.done_tag    = tag_eff;
                    res_item.done_status = csre_pkg::ST_FULL;
                end else begin
                    ins     = 1'b1;
                    n_count = r_count + CW'(1);
                    if (i_work.cls.is_crit) n_crit = r_crit + CW'(1);
                    if (it.request_tag == 16'd0) begin
                        n_next_tag = (r_next_tag == csre_pkg::TAG_LAST) ? 16'd1
                                                                       : r_next_tag + 16'd1;
                    end
                end
            end
            csre_pkg::OP_RX: begin
                if (r_busy && r_act.wants && it.frame_id == r_act.rid
                        && it.frame_len >= csre_pkg::MIN_RX_LEN
                        && it.frame_bytes[23:8] == r_act.idx
                        && it.frame_bytes[31:24] == r_act.sub) begin
                    n_busy               = 1'b0;
                    res                  = 1'b1;
                    res_item.out_kind    = csre_pkg::KIND_DONE;
                    res_item.out_len     = (it.frame_len > csre_pkg::MAX_LEN)
                                           ? csre_pkg::MAX_LEN : it.frame_len;
                    res_item.out_bytes   = it.frame_bytes;
                    res_item.done_tag    = r_act.tag;
                    res_item.done_status = (it.frame_bytes[7:0] == csre_pkg::REJECT_CODE)
                                           ? csre_pkg::ST_REJECTED : csre_pkg::ST_OK;
                    res_item.latency_ms  = r_elapsed;
                end
            end
            csre_pkg::OP_REFUSE: begin
                if (r_busy) begin
                    n_busy               = 1'b0;
                    res                  = 1'b1;
                    res_item.out_kind    = csre_pkg::KIND_DONE;
                    res_item.done_tag    = r_act.tag;
                    res_item.done_status = csre_pkg::ST_SENDFAIL;
                    res_item.latency_ms  = r_elapsed;
                end
            end
            default: begin
                if (r_busy) begin
                    if (r_elapsed >= limit) begin
                        n_busy               = 1'b0;
                        res                  = 1'b1;
                        res_item.out_kind    = csre_pkg::KIND_DONE;
                        res_item.done_tag    = r_act.tag;
                        res_item.done_status = r_act.wants ? csre_pkg::ST_TIMEOUT
                                                           : csre_pkg::ST_OK;
                        res_item.latency_ms  = r_elapsed;
                    end else begin
                        n_elapsed = r_elapsed + 16'd1;
                    end
                end else if (phase_inc < period) begin
                    n_phase = phase_inc;
                end else begin
                    n_phase = 8'd0;
                    if (r_count != '0) begin
                        deq                   = 1'b1;
                        n_count               = r_count - CW'(1);
                        if (r_crit != '0) n_crit = r_crit - CW'(1);
                        n_act                 = r_slot[0];
                        n_busy                = 1'b1;
                        n_elapsed             = 16'd0;
                        res                   = 1'b1;
                        res_item.out_kind     = csre_pkg::KIND_FRAME;
                        res_item.out_frame_id = r_slot[0].fid;
                        res_item.out_len      = r_slot[0].len;
                        res_item.out_bytes    = r_slot[0].bytes;
                        res_item.done_tag     = r_slot[0].tag;
                    end
                end
            end
        endcase
    end

    // per-slot shift: insert opens a gap at pos, dispatch moves all up by one
    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            n_slot[i] = r_slot[i];
            if (ins) begin
                if (CW'(i) == pos) n_slot[i] = new_slot;
                else if (i > 0 && CW'(i) > pos && CW'(i) <= r_count) n_slot[i] = r_slot[i-1];
            end else if (deq && i < QUEUE_DEPTH - 1) begin
                n_slot[i] = r_slot[i+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            r_slot <= n_slot;
            r_act  <= n_act;
        end
        if (go && res) r_out <= res_item;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_crit     <= '0;
            r_next_tag <= 16'd1;
            r_busy     <= 1'b0;
            r_elapsed  <= 16'd0;
            r_phase    <= 8'd0;
            r_ov       <= 1'b0;
        end else begin
            if (go) begin
                r_count    <= n_count;
                r_crit     <= n_crit;
                r_next_tag <= n_next_tag;
                r_busy     <= n_busy;
                r_elapsed  <= n_elapsed;
                r_phase    <= n_phase;
            end
            if (go && res)        r_ov <= 1'b1;
            else if (!i_out_stall) r_ov <= 1'b0;
        end
    end
endmodule

/* src/can_sdo_request_engine_unit.sv */
// top level of the can sdo request engine
//
//  channel | direction | beat        | handshake
//  in      | input     | t_in_item   | i_in_valid / o_in_stall
//  out     | output    | t_out_item  | o_out_valid / i_out_stall
//  cfg     | input     | 2 registers | apb psel / penable / pwrite, pready tied high
//
// an accepted beat sits in a two-entry buffer in the front; with the buffer empty its
// result is valid after the front buffer and then the back's result register
// sustained rate is one beat per cycle while the result register drains; the
// back's single decode pass (queue shift plus transaction update) sets it
// reset is synchronous; it clears counters, tags and the buffer, not the slots
// a stalled result register holds the back, the front keeps taking beats until
// its buffer is full
`include "assert_macros.svh"

module can_sdo_request_engine_unit #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input channel
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  csre_pkg::t_in_item  i_in_item,
    // output channel
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output csre_pkg::t_out_item o_out_item,
    // configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic                   cfg_sel_period, cfg_wr;
    logic [7:0]             r_cfg_period, r_cfg_hold;
    logic                   work_valid, work_take;
    csre_pkg::t_work        work;
    csre_pkg::t_back_status st;
    logic [CW-1:0]          count;

    // config registers, decoded on word address only
    assign pready = 1'b1;
    assign prdata = (paddr[2] == csre_pkg::REG_HOLD) ? {24'd0, r_cfg_hold}
                                                     : {24'd0, r_cfg_period};
    assign cfg_sel_period = (paddr[2] == csre_pkg::REG_PERIOD);
    assign cfg_wr         = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_period <= csre_pkg::PERIOD_RESET;
            r_cfg_hold   <= csre_pkg::HOLD_RESET;
        end else if (cfg_wr) begin
            if (cfg_sel_period) r_cfg_period <= pwdata[7:0];
            else                r_cfg_hold   <= pwdata[7:0];
        end
    end

    // front end: accept and classify
    csre_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_item    (i_in_item),
        .o_work_valid (work_valid),
        .o_work       (work),
        .i_work_take  (work_take)
    );

    // back end: queue, transaction and result register
    csre_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .CW          (CW)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_work_valid (work_valid),
        .i_work       (work),
        .o_work_take  (work_take),
        .i_cfg_period (r_cfg_period),
        .i_cfg_hold   (r_cfg_hold),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_item   (o_out_item),
        .o_status     (st),
        .o_count      (count)
    );

    `CSRE_ASSERT_NEVER(a_count_bound, i_clk, i_rst_n, count > CW'(QUEUE_DEPTH), "queue overrun")
    `CSRE_ASSERT_IMPL(a_full_flag, i_clk, i_rst_n, st.queue_full, count == CW'(QUEUE_DEPTH), "full flag without full queue")
    `CSRE_ASSERT_IMPL(a_dispatch_frame, i_clk, i_rst_n, $rose(st.busy), o_out_valid && o_out_item.out_kind == csre_pkg::KIND_FRAME, "dispatch without frame")
    `CSRE_ASSERT_IMPL(a_frame_clean, i_clk, i_rst_n, o_out_valid && o_out_item.out_kind == csre_pkg::KIND_FRAME, o_out_item.done_status == csre_pkg::ST_OK && o_out_item.latency_ms == 16'd0, "frame with status")
endmodule
